### rtl/qs_pkg.sv
// Shared constants for the quicksort engine.
`default_nettype none
package qs_pkg;

    // Width of one stored value and of the stream data words.
    localparam int unsigned VALUE_W = 32;

    typedef logic signed [VALUE_W-1:0] value_t;

endpackage
`default_nettype wire

### rtl/quicksort_engine.sv
// Top level of the quicksort engine: load, in-memory quicksort and ordered read-out.
//
//  Channel  Direction  Handshake          Payload
//  s_       in         s_tvalid/s_tready  s_tdata = item_value, s_tlast = last_item
//  m_       out        m_tvalid/m_tready  m_tdata = sorted_value, m_tlast = last_out,
//                                         m_tuser = dropped_flag
//
// Loading accepts one item per cycle. Sorting runs out of the value RAM, which has
// one read and one write port: each pointer step of a partition is a read state
// and then a compare state, a swap is two writes, and each range adds pop,
// pivot-read and final-placement states. Read-out steps through read, wait and
// hold states for each item, and the hold state waits for m_tready.
// Reset clears the control state only; the RAM contents are never cleared.
// No item is accepted while a set is being sorted or emitted.
`default_nettype none
module quicksort_engine #(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [qs_pkg::VALUE_W-1:0] s_tdata,  // [31:0] item_value
    input  wire logic                      s_tlast,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic      [qs_pkg::VALUE_W-1:0] m_tdata,  // [31:0] sorted_value
    output logic                           m_tlast,
    output logic      [0:0]                m_tuser   // [0] dropped_flag
);
    import qs_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_ITEMS);
    localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int unsigned ENT_W = 2 * IDX_W;

    typedef enum logic [4:0] {
        ST_LOAD, ST_SORT_INIT, ST_POP, ST_POP_WAIT, ST_PIV_WAIT,
        ST_SCAN_R, ST_SCAN_R_CHK, ST_SCAN_L, ST_SCAN_L_CHK, ST_SWAP1, ST_SWAP2,
        ST_FINAL, ST_FIN_RD, ST_FIN_WR, ST_PUSH_HI,
        ST_EMIT_RD, ST_EMIT_WAIT, ST_EMIT_HOLD
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [CNT_W-1:0]   top_reg, top_next;
    logic [IDX_W-1:0]   lo_reg, lo_next;
    logic [IDX_W-1:0]   hi_reg, hi_next;
    logic [IDX_W:0]     l_reg, l_next;
    logic [IDX_W-1:0]   r_reg, r_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    value_t             pivot_reg, pivot_next;
    value_t             val_l_reg, val_l_next;
    value_t             val_r_reg, val_r_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [VALUE_W-1:0] m_tdata_reg, m_tdata_next;
    logic               m_tlast_reg, m_tlast_next;
    logic               m_tuser_reg, m_tuser_next;

    logic               v_we, v_re;
    logic [IDX_W-1:0]   v_waddr, v_raddr;
    logic [VALUE_W-1:0] v_wdata, v_rdata;
    logic               st_we, st_re;
    logic [IDX_W-1:0]   st_waddr, st_raddr;
    logic [ENT_W-1:0]   st_wdata, st_rdata;

    value_t             rd_val;
    logic [IDX_W:0]     r_ext;
    logic               l_le_r;
    logic               l_lt_r;
    logic               in_acc;

    assign rd_val = value_t'(v_rdata);
    assign r_ext  = {1'b0, r_reg};
    assign l_le_r = (l_reg <= r_ext);
    assign l_lt_r = (l_reg < r_ext);
    assign in_acc = s_tvalid && s_tready;

    assign s_tready   = (state_reg == ST_LOAD);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tlast    = m_tlast_reg;
    assign m_tuser[0] = m_tuser_reg;

    qs_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(MAX_ITEMS)
    ) u_value_ram (
        .aclk (aclk),
        .we   (v_we),
        .waddr(v_waddr),
        .wdata(v_wdata),
        .re   (v_re),
        .raddr(v_raddr),
        .rdata(v_rdata)
    );

    // Pending ranges, low index in the upper half and high index in the lower half.
    qs_ram #(
        .WIDTH(ENT_W),
        .DEPTH(MAX_ITEMS)
    ) u_stack_ram (
        .aclk (aclk),
        .we   (st_we),
        .waddr(st_waddr),
        .wdata(st_wdata),
        .re   (st_re),
        .raddr(st_raddr),
        .rdata(st_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        top_next      = top_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        l_next        = l_reg;
        r_next        = r_reg;
        k_next        = k_reg;
        pivot_next    = pivot_reg;
        val_l_next    = val_l_reg;
        val_r_next    = val_r_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;

        v_we     = 1'b0;
        v_waddr  = r_reg;
        v_wdata  = VALUE_W'(pivot_reg);
        v_re     = 1'b0;
        v_raddr  = r_reg;
        st_we    = 1'b0;
        st_waddr = top_reg[IDX_W-1:0];
        st_wdata = {lo_reg, r_reg - IDX_W'(1)};
        st_re    = 1'b0;
        st_raddr = top_reg[IDX_W-1:0] - IDX_W'(1);

        unique case (state_reg)
            ST_LOAD: begin
                if (in_acc) begin
                    if (count_reg < CNT_W'(MAX_ITEMS)) begin
                        v_we       = 1'b1;
                        v_waddr    = count_reg[IDX_W-1:0];
                        v_wdata    = s_tdata;
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        state_next = ST_SORT_INIT;
                    end
                end
            end
            ST_SORT_INIT: begin
                k_next = '0;
                if (count_reg >= CNT_W'(2)) begin
                    st_we      = 1'b1;
                    st_waddr   = '0;
                    st_wdata   = {IDX_W'(0), IDX_W'(count_reg - CNT_W'(1))};
                    top_next   = CNT_W'(1);
                    state_next = ST_POP;
                end else begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_POP: begin
                if (top_reg == '0) begin
                    k_next     = '0;
                    state_next = ST_EMIT_RD;
                end else begin
                    st_re      = 1'b1;
                    top_next   = top_reg - CNT_W'(1);
                    state_next = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT: begin
                lo_next    = st_rdata[ENT_W-1:IDX_W];
                hi_next    = st_rdata[IDX_W-1:0];
                l_next     = {1'b0, st_rdata[ENT_W-1:IDX_W]} + (IDX_W + 1)'(1);
                r_next     = st_rdata[IDX_W-1:0];
                v_re       = 1'b1;
                v_raddr    = st_rdata[ENT_W-1:IDX_W];
                state_next = ST_PIV_WAIT;
            end
            ST_PIV_WAIT: begin
                pivot_next = rd_val;
                state_next = ST_SCAN_R;
            end
            // This state also serves as the test of the outer partition loop.
            ST_SCAN_R: begin
                if (l_le_r) begin
                    v_re       = 1'b1;
                    v_raddr    = r_reg;
                    state_next = ST_SCAN_R_CHK;
                end else begin
                    state_next = ST_FINAL;
                end
            end
            ST_SCAN_R_CHK: begin
                if (pivot_reg <= rd_val) begin
                    r_next     = r_reg - IDX_W'(1);
                    state_next = ST_SCAN_R;
                end else begin
                    val_r_next = rd_val;
                    state_next = ST_SCAN_L;
                end
            end
            ST_SCAN_L: begin
                if (l_le_r) begin
                    v_re       = 1'b1;
                    v_raddr    = l_reg[IDX_W-1:0];
                    state_next = ST_SCAN_L_CHK;
                end else begin
                    state_next = ST_FINAL;
                end
            end
            ST_SCAN_L_CHK: begin
                if (rd_val <= pivot_reg) begin
                    l_next     = l_reg + (IDX_W + 1)'(1);
                    state_next = ST_SCAN_L;
                end else begin
                    val_l_next = rd_val;
                    state_next = l_lt_r ? ST_SWAP1 : ST_SCAN_R;
                end
            end
            ST_SWAP1: begin
                v_we       = 1'b1;
                v_waddr    = l_reg[IDX_W-1:0];
                v_wdata    = VALUE_W'(val_r_reg);
                state_next = ST_SWAP2;
            end
            ST_SWAP2: begin
                v_we       = 1'b1;
                v_waddr    = r_reg;
                v_wdata    = VALUE_W'(val_l_reg);
                state_next = ST_SCAN_R;
            end
            ST_FINAL: begin
                v_re       = 1'b1;
                v_raddr    = r_reg;
                state_next = ST_FIN_RD;
            end
            ST_FIN_RD: begin
                // The pivot still sits at the low end of the range.
                v_we       = 1'b1;
                v_waddr    = lo_reg;
                v_wdata    = v_rdata;
                state_next = ST_FIN_WR;
            end
            ST_FIN_WR: begin
                v_we    = 1'b1;
                v_waddr = r_reg;
                v_wdata = VALUE_W'(pivot_reg);
                if (r_ext >= {1'b0, lo_reg} + (IDX_W + 1)'(2)) begin
                    st_we    = 1'b1;
                    st_wdata = {lo_reg, r_reg - IDX_W'(1)};
                    top_next = top_reg + CNT_W'(1);
                end
                state_next = ST_PUSH_HI;
            end
            ST_PUSH_HI: begin
                if ({1'b0, hi_reg} >= r_ext + (IDX_W + 1)'(2)) begin
                    st_we    = 1'b1;
                    st_wdata = {r_reg + IDX_W'(1), hi_reg};
                    top_next = top_reg + CNT_W'(1);
                end
                state_next = ST_POP;
            end
            ST_EMIT_RD: begin
                v_re       = 1'b1;
                v_raddr    = k_reg;
                state_next = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = v_rdata;
                m_tlast_next  = (k_reg == IDX_W'(count_reg - CNT_W'(1)));
                m_tuser_next  = ovf_reg;
                state_next    = ST_EMIT_HOLD;
            end
            ST_EMIT_HOLD: begin
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    if (m_tlast_reg) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end else begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            top_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            top_reg      <= top_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        l_reg       <= l_next;
        r_reg       <= r_next;
        k_reg       <= k_next;
        pivot_reg   <= pivot_next;
        val_l_reg   <= val_l_next;
        val_r_reg   <= val_r_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule
`default_nettype wire

### rtl/qs_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
`default_nettype none
module qs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire
